// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the timer pool checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define MST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define MST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg
// Types, codes and constants shared by the timer pool modules.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int MAX_FIRE    = 8;
  localparam int FIRE_W      = $clog2(MAX_FIRE);
  localparam int MODE_W      = 3;
  localparam int ID_W        = 4;
  localparam int PER_W       = 32;
  localparam int REP_W       = 8;
  localparam logic [REP_W-1:0] REP_FOREVER = 8'hFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_START   = 3'd1,
    MODE_RESTART = 3'd2,
    MODE_CANCEL  = 3'd3,
    MODE_PROCESS = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic pend_valid;
    logic out_free;
    logic scan_last;
    logic fire_cap;
  } status_t;

endpackage

// ===== rtl/multi_slot_repeat_timer.sv =====
// Tick, start, restart, cancel: the item is latched, run in the OP state once the output
// register is free, and the result registered to out_valid. Process: one slot per cycle
// unless a firing stalls on the busy output register; the scan ends early at the firing cap.
// One item at a time. The scan rate is set by the single slot-storage read port walked by the
// scan pointer. Reset (rst_n low, synchronous): tick counter zero, all slots free, no beat
// pending. Slot start, period and repeat storage is not cleared; only active slots use it.
// ----------------------------------------------------------------------------
// multi_slot_repeat_timer
// Pool of SLOTS repeating timers on a tick counter advanced by tick items, with
// start, restart, cancel and an in-order expiration scan.
// ----------------------------------------------------------------------------
module multi_slot_repeat_timer #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mst_pkg::MODE_W-1:0]  in_mode,
  input  logic [mst_pkg::ID_W-1:0]    in_slot_id,
  input  logic [mst_pkg::PER_W-1:0]   in_period,
  input  logic [mst_pkg::REP_W-1:0]   in_repeat_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mst_pkg::ID_W-1:0]    out_slot_id_res,
  output logic                        out_ok,
  output logic                        out_fired,
  output logic                        out_last
);

  // Commands from the sequencer, status back from the datapath.
  mst_pkg::cmd_t    cmd;
  mst_pkg::status_t sts;

  // The sequencer decides per cycle: latch an item, run a one-shot
  // operation, advance the scan one slot, or close the scan with the
  // final beat. A firing is held back until the next firing or the end
  // of the scan, so the last flag can be set on it once no later slot fires.
  mst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the counter, slot storage and the output register,
  // so a new item can be accepted while the previous result still waits.
  mst_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_slot_id      (in_slot_id),
    .in_period       (in_period),
    .in_repeat_count (in_repeat_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_slot_id_res (out_slot_id_res),
    .out_ok          (out_ok),
    .out_fired       (out_fired),
    .out_last        (out_last)
  );

endmodule

// ===== rtl/mst_ctrl.sv =====
// ----------------------------------------------------------------------------
// mst_ctrl
// Sequencer: accepts an item, runs a one-shot operation or the slot scan.
// ----------------------------------------------------------------------------
module mst_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mst_pkg::MODE_W-1:0]  in_mode,
  input  mst_pkg::status_t            sts,
  output mst_pkg::cmd_t               cmd
);

  mst_pkg::state_t state_r, state_nxt;
  logic stall;

  // Hold the scan when a second firing needs the busy output register.
  assign stall = sts.hit && sts.pend_valid && !sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mst_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_mode == mst_pkg::MODE_PROCESS) ? mst_pkg::ST_SCAN : mst_pkg::ST_OP;
        end
      end
      mst_pkg::ST_OP: begin
        if (sts.out_free) begin
          state_nxt = mst_pkg::ST_IDLE;
        end
      end
      mst_pkg::ST_SCAN: begin
        if (!stall && (sts.scan_last || (sts.hit && sts.fire_cap))) begin
          state_nxt = mst_pkg::ST_DONE;
        end
      end
      mst_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = mst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == mst_pkg::ST_IDLE);
    cmd.load   = (state_r == mst_pkg::ST_IDLE) && in_valid;
    cmd.exec   = (state_r == mst_pkg::ST_OP) && sts.out_free;
    cmd.step   = (state_r == mst_pkg::ST_SCAN) && !stall;
    cmd.finish = (state_r == mst_pkg::ST_DONE) && sts.out_free;
  end

endmodule

// ===== rtl/mst_datapath.sv =====
// ----------------------------------------------------------------------------
// mst_datapath
// Tick counter, slot storage, scan pointer and the result output register.
// ----------------------------------------------------------------------------
module mst_datapath #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mst_pkg::cmd_t               cmd,
  output mst_pkg::status_t            sts,
  input  logic [mst_pkg::MODE_W-1:0]  in_mode,
  input  logic [mst_pkg::ID_W-1:0]    in_slot_id,
  input  logic [mst_pkg::PER_W-1:0]   in_period,
  input  logic [mst_pkg::REP_W-1:0]   in_repeat_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mst_pkg::ID_W-1:0]    out_slot_id_res,
  output logic                        out_ok,
  output logic                        out_fired,
  output logic                        out_last
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W   = mst_pkg::ID_W;
  localparam int PER_W  = mst_pkg::PER_W;
  localparam int REP_W  = mst_pkg::REP_W;
  localparam int FIRE_W = mst_pkg::FIRE_W;

  // Item registers
  logic [mst_pkg::MODE_W-1:0] mode_r;
  logic [ID_W-1:0]            id_r;
  logic [PER_W-1:0]           per_r;
  logic [REP_W-1:0]           rep_r;

  logic [PER_W-1:0] now_r;
  logic [SLOTS-1:0] active_r;
  logic [PER_W-1:0] start_mem [SLOTS];
  logic [PER_W-1:0] per_mem   [SLOTS];
  logic [REP_W-1:0] rep_mem   [SLOTS];

  logic [IDX_W-1:0]  idx_r;
  logic [FIRE_W-1:0] nfire_r;
  logic              pend_valid_r;
  logic [IDX_W-1:0]  pend_id_r;

  logic              out_valid_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_ok_r, out_fired_r, out_last_r;

  logic              id_in_range, id_ok;
  logic [IDX_W-1:0]  id_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [PER_W-1:0]  rd_start, rd_per, elapsed;
  logic [REP_W-1:0]  rd_rep, rep_dec;
  logic              hit, out_free;

  logic              ld;
  logic [ID_W-1:0]   res_id;
  logic              res_ok, res_fired, res_last;

  logic              wr_all, wr_hit;
  logic [IDX_W-1:0]  wr_addr;
  logic [REP_W-1:0]  wr_rep;
  logic              set_act, clr_act;
  logic [IDX_W-1:0]  act_addr;
  logic              do_tick;

  assign id_in_range = {1'b0, id_r} < (ID_W + 1)'(SLOTS);
  assign id_idx      = id_r[IDX_W-1:0];
  assign id_ok       = id_in_range && active_r[id_idx];

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign rd_start = start_mem[idx_r];
  assign rd_per   = per_mem[idx_r];
  assign rd_rep   = rep_mem[idx_r];
  assign elapsed  = now_r - rd_start;
  assign hit      = active_r[idx_r] && (elapsed >= rd_per);
  assign rep_dec  = (rd_rep != mst_pkg::REP_FOREVER && rd_rep != '0) ?
                    rd_rep - REP_W'(1) : rd_rep;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    sts.hit        = hit;
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
    sts.scan_last  = (idx_r == IDX_W'(SLOTS - 1));
    sts.fire_cap   = (nfire_r == FIRE_W'(mst_pkg::MAX_FIRE - 1));
  end

  // Result and state update selection
  always_comb begin
    ld        = 1'b0;
    res_id    = '0;
    res_ok    = 1'b0;
    res_fired = 1'b0;
    res_last  = 1'b1;
    wr_all    = 1'b0;
    wr_hit    = 1'b0;
    wr_addr   = idx_r;
    wr_rep    = rep_dec;
    set_act   = 1'b0;
    clr_act   = 1'b0;
    act_addr  = idx_r;
    do_tick   = 1'b0;
    if (cmd.exec) begin
      ld = 1'b1;
      unique case (mode_r)
        mst_pkg::MODE_TICK: begin
          do_tick = 1'b1;
          res_ok  = 1'b1;
        end
        mst_pkg::MODE_START: begin
          res_ok   = free_found;
          res_id   = free_found ? ID_W'(free_idx) : '0;
          wr_all   = free_found;
          wr_addr  = free_idx;
          wr_rep   = rep_r;
          set_act  = free_found;
          act_addr = free_idx;
        end
        mst_pkg::MODE_RESTART: begin
          res_ok  = id_ok;
          res_id  = id_r;
          wr_all  = id_ok;
          wr_addr = id_idx;
          wr_rep  = rep_r;
        end
        mst_pkg::MODE_CANCEL: begin
          res_ok   = id_ok;
          res_id   = id_r;
          clr_act  = id_ok;
          act_addr = id_idx;
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end else if (cmd.step) begin
      if (hit) begin
        wr_hit  = 1'b1;
        clr_act = (rep_dec == '0);
        // Push the previous firing; it is not the final one.
        ld        = pend_valid_r;
        res_id    = ID_W'(pend_id_r);
        res_ok    = 1'b1;
        res_fired = 1'b1;
        res_last  = 1'b0;
      end
    end else if (cmd.finish) begin
      ld        = 1'b1;
      res_ok    = 1'b1;
      res_fired = pend_valid_r;
      res_id    = pend_valid_r ? ID_W'(pend_id_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      id_r   <= in_slot_id;
      per_r  <= in_period;
      rep_r  <= in_repeat_count;
    end
    if (wr_all || wr_hit) begin
      start_mem[wr_addr] <= now_r;
      rep_mem[wr_addr]   <= wr_rep;
    end
    if (wr_all) begin
      per_mem[wr_addr] <= per_r;
    end
    if (cmd.step && hit) begin
      pend_id_r <= idx_r;
    end
    if (ld) begin
      out_id_r    <= res_id;
      out_ok_r    <= res_ok;
      out_fired_r <= res_fired;
      out_last_r  <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r        <= '0;
      active_r     <= '0;
      idx_r        <= '0;
      nfire_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (do_tick) begin
        now_r <= now_r + PER_W'(1);
      end
      if (set_act) begin
        active_r[act_addr] <= 1'b1;
      end else if (clr_act) begin
        active_r[act_addr] <= 1'b0;
      end
      if (cmd.load) begin
        idx_r        <= '0;
        nfire_r      <= '0;
        pend_valid_r <= 1'b0;
      end else if (cmd.step) begin
        idx_r <= idx_r + IDX_W'(1);
        if (hit) begin
          nfire_r      <= nfire_r + FIRE_W'(1);
          pend_valid_r <= 1'b1;
        end
      end
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_id_res = out_id_r;
  assign out_ok          = out_ok_r;
  assign out_fired       = out_fired_r;
  assign out_last        = out_last_r;

endmodule

// ===== rtl/mst_checker.sv =====
// ----------------------------------------------------------------------------
// mst_checker
// Port-level checks on the timer pool, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mst_checker #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mst_pkg::ID_W-1:0]    out_slot_id_res,
  input logic                        out_ok,
  input logic                        out_fired,
  input logic                        out_last
);

  logic                        out_beat;
  logic                        in_beat;
  logic                        out_stall;
  logic                        slot_legal;
  logic [mst_pkg::ID_W+2:0]    out_word;

  assign out_beat   = out_valid && out_ready;
  assign in_beat    = in_valid && in_ready;
  assign out_stall  = out_valid && !out_ready;
  assign slot_legal = {1'b0, out_slot_id_res} < (mst_pkg::ID_W + 1)'(SLOTS);
  assign out_word   = {out_slot_id_res, out_ok, out_fired, out_last};

  // A stalled result beat holds.
  `MST_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled beat changed")
  // Firings always report success on a real slot.
  `MST_ASSERT_NOW(a_fire_ok, out_beat && out_fired, out_ok && slot_legal, "bad firing beat")
  // Anything other than a firing is the only beat of its item.
  `MST_ASSERT_NOW(a_single_last, out_beat && !out_fired, out_last, "non-firing beat without last")
  // Items are handled one at a time.
  `MST_ASSERT_NEXT(a_one_item, in_beat, !in_ready, "input accepted on consecutive cycles")

endmodule

bind multi_slot_repeat_timer mst_checker #(
  .SLOTS (SLOTS)
) u_mst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_slot_id_res (out_slot_id_res),
  .out_ok          (out_ok),
  .out_fired       (out_fired),
  .out_last        (out_last)
);
